// ----- src/mfc_pkg.sv -----
// Shared types, constants and helpers for the mailbox FIFO channel port.
// Used by the top level, the port checker and the testbench.
package mfc_pkg;

   // Field widths fixed by the bus
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = 7;
   localparam int IRQ_W    = 8;
   localparam int CH_SEL_W = 2;

   // Default sizes
   localparam int DEF_CHANNELS   = 4;
   localparam int DEF_FIFO_DEPTH = 8;

   // Register map
   localparam logic [ADDR_W-1:0] ADDR_IRQ_EN  = 7'h20;
   localparam logic [ADDR_W-1:0] ADDR_IRQ_STA = 7'h24;
   localparam logic [2:0]        GRP_STATUS   = 3'h6;   // 0x60 + 4c
   localparam logic [2:0]        GRP_FIFO     = 3'h7;   // 0x70 + 4c
   localparam logic [DATA_W-1:0] COUNT_MASK   = 32'h0000_000F;

   typedef enum logic [0:0] {
      CMD_READ  = 1'b0,
      CMD_WRITE = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      REG_IRQ_EN,
      REG_IRQ_STA,
      REG_STATUS,
      REG_FIFO,
      REG_NONE
   } region_type;

   // One enable/status bit per channel, at bit 2*c
   function automatic logic [IRQ_W-1:0] chan_mask(input int channels);
      logic [IRQ_W-1:0] m;
      m = '0;
      for (int c = 0; c < IRQ_W / 2; c++) begin
         if (c < channels) begin
            m[2*c] = 1'b1;
         end
      end
      return m;
   endfunction

endpackage

// ----- src/mfc_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module mfc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/mailbox_fifo_channels.sv -----
// One port of a message box: per-channel word FIFOs behind a small register map.
// Depends on mfc_pkg and mfc_ram.
//
// Usage:
//   Request channel: drive req_command (0 read, 1 write), req_address (byte
//   offset) and req_write_data with start high; a transaction is taken at
//   each rising edge where start is high and busy is low. busy stays low,
//   so a transaction may be issued every cycle.
//   Response channel: exactly one response per transaction, on rsp_valid
//   for one cycle, in the cycle after the request was taken. It carries the
//   read data (0 for writes), the irq level after the transaction and the
//   access error flag.
//   Throughput: 1 transaction per cycle. Pointers, counts
//   and interrupt bits update at the accept edge; the FIFO word RAM is
//   written (push) or read (pop) at that same edge, and its registered read
//   port supplies popped words in the response cycle.
//   Reset: clears head pointers, word counts, interrupt enable and status,
//   and the response strobe. FIFO words are not cleared; only pushed words
//   are ever popped.
//   The receiver cannot hold off responses; none is buffered.
module mailbox_fifo_channels #(
   parameter int CHANNELS   = mfc_pkg::DEF_CHANNELS,
   parameter int FIFO_DEPTH = mfc_pkg::DEF_FIFO_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_command,
   input  logic [mfc_pkg::ADDR_W-1:0] req_address,
   input  logic [mfc_pkg::DATA_W-1:0] req_write_data,
   output logic                       rsp_valid,
   output logic [mfc_pkg::DATA_W-1:0] rsp_read_data,
   output logic                       rsp_irq,
   output logic                       rsp_access_error
);
   import mfc_pkg::*;

   localparam int PTR_W  = $clog2(FIFO_DEPTH);
   localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
   localparam int SUM_W  = PTR_W + 1;
   localparam int SLOTS  = CHANNELS * FIFO_DEPTH;
   localparam int RAM_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IRQ_W-1:0] IRQ_MASK = chan_mask(CHANNELS);

   // Per-channel pointer state
   logic [PTR_W-1:0] head_ff  [CHANNELS];
   logic [CNT_W-1:0] count_ff [CHANNELS];
   logic [IRQ_W-1:0] enable_ff, enable_in;
   logic [IRQ_W-1:0] pending_ff, pending_in;

   // Response registers
   logic              rsp_valid_ff;
   logic              pop_sel_ff;
   logic [DATA_W-1:0] rdata_ff, rdata_in;
   logic              irq_ff;
   logic              err_ff, err_in;

   logic                accept;
   logic [CH_SEL_W-1:0] ch;
   logic                aligned;
   logic                ch_ok;
   region_type          region;
   logic [PTR_W-1:0]    cur_head, head_next, tail;
   logic [CNT_W-1:0]    cur_cnt;
   logic [SUM_W-1:0]    tail_sum;
   logic                full, empty, is_write, push, pop;
   logic [RAM_AW-1:0]   ram_waddr, ram_raddr;
   logic [DATA_W-1:0]   ram_rdata;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Decode the address
   assign ch       = req_address[3:2];
   assign aligned  = (req_address[1:0] == 2'b00);
   assign ch_ok    = (32'(ch) < CHANNELS);
   assign is_write = (req_command == CMD_WRITE);

   always_comb begin
      if (aligned && req_address == ADDR_IRQ_EN) begin
         region = REG_IRQ_EN;
      end else if (aligned && req_address == ADDR_IRQ_STA) begin
         region = REG_IRQ_STA;
      end else if (aligned && ch_ok && req_address[6:4] == GRP_STATUS) begin
         region = REG_STATUS;
      end else if (aligned && ch_ok && req_address[6:4] == GRP_FIFO) begin
         region = REG_FIFO;
      end else begin
         region = REG_NONE;
      end
   end

   // Select the addressed channel's pointers
   always_comb begin
      cur_head = '0;
      cur_cnt  = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (ch == CH_SEL_W'(c)) begin
            cur_head = head_ff[c];
            cur_cnt  = count_ff[c];
         end
      end
   end

   // Tail slot and next head, wrapped at the FIFO depth
   assign full      = (cur_cnt == CNT_W'(FIFO_DEPTH));
   assign empty     = (cur_cnt == '0);
   assign tail_sum  = SUM_W'(cur_head) + SUM_W'(cur_cnt);
   assign tail      = (tail_sum >= SUM_W'(FIFO_DEPTH)) ?
                      PTR_W'(tail_sum - SUM_W'(FIFO_DEPTH)) : PTR_W'(tail_sum);
   assign head_next = (cur_head == PTR_W'(FIFO_DEPTH - 1)) ? '0 : cur_head + 1'b1;

   assign push = accept && region == REG_FIFO && is_write && !full;
   assign pop  = accept && region == REG_FIFO && !is_write && !empty;

   assign ram_waddr = RAM_AW'(32'(ch) * FIFO_DEPTH + 32'(tail));
   assign ram_raddr = RAM_AW'(32'(ch) * FIFO_DEPTH + 32'(cur_head));

   // Register side effects and immediate read data
   always_comb begin
      enable_in  = enable_ff;
      pending_in = pending_ff;
      rdata_in   = '0;
      err_in     = 1'b0;
      unique case (region)
         REG_IRQ_EN: begin
            if (is_write) enable_in = req_write_data[IRQ_W-1:0] & IRQ_MASK;
            else          rdata_in  = DATA_W'(enable_ff);
         end
         REG_IRQ_STA: begin
            if (is_write) pending_in = pending_ff & ~req_write_data[IRQ_W-1:0];
            else          rdata_in   = DATA_W'(pending_ff);
         end
         REG_STATUS: begin
            if (!is_write) rdata_in = DATA_W'(cur_cnt) & COUNT_MASK;
         end
         REG_FIFO: begin
            if (is_write) begin
               if (full) err_in = 1'b1;
               else      pending_in = pending_ff | (IRQ_W'(1) << {ch, 1'b0});
            end else if (empty) begin
               err_in = 1'b1;
            end
         end
         default: err_in = 1'b1;
      endcase
   end

   // Advance channel pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            head_ff[c]  <= '0;
            count_ff[c] <= '0;
         end
      end else begin
         for (int c = 0; c < CHANNELS; c++) begin
            if (ch == CH_SEL_W'(c)) begin
               if (push) begin
                  count_ff[c] <= cur_cnt + 1'b1;
               end else if (pop) begin
                  head_ff[c]  <= head_next;
                  count_ff[c] <= cur_cnt - 1'b1;
               end
            end
         end
      end
   end

   // Hold interrupt enable and status
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= '0;
         pending_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            enable_ff  <= enable_in;
            pending_ff <= pending_in;
         end
      end
   end

   // Capture the response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         pop_sel_ff <= pop;
         rdata_ff   <= rdata_in;
         irq_ff     <= |(pending_in & enable_in);
         err_ff     <= err_in;
      end
   end

   mfc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (SLOTS)
   ) u_words (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (ram_waddr),
      .wr_data (req_write_data),
      .rd_en   (pop),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = pop_sel_ff ? ram_rdata : rdata_ff;
   assign rsp_irq          = irq_ff;
   assign rsp_access_error = err_ff;

endmodule

// ----- src/mfc_checker.sv -----
// Port-level checks for the mailbox FIFO channel port, bound to the top level.
// Depends on mfc_pkg.
module mfc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       req_command,
   input logic [mfc_pkg::ADDR_W-1:0] req_address,
   input logic                       rsp_valid,
   input logic [mfc_pkg::DATA_W-1:0] rsp_read_data,
   input logic                       rsp_access_error
);
   import mfc_pkg::*;

   // Every transaction gets a response on the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("transaction without a response");

   // No response without a transaction
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("response without a transaction");

   // Writes return zero data
   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == CMD_WRITE) |=> (rsp_read_data == '0))
      else $error("write returned nonzero data");

   // Unaligned addresses always flag an error
   a_unaligned: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_address[1:0] != 2'b00) |=> rsp_access_error)
      else $error("unaligned access without error");

   // Nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response after reset");

endmodule

bind mailbox_fifo_channels mfc_checker u_mfc_checker (.*);

// ----- test/mailbox_fifo_channels_tb.sv -----
// Self-checking testbench for mailbox_fifo_channels: register accesses with checked responses.
// Depends on mfc_pkg and the mailbox_fifo_channels RTL.

module mailbox_fifo_channels_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mfc_pkg::*;

   localparam int CHANNELS    = DEF_CHANNELS;
   localparam int FIFO_DEPTH  = DEF_FIFO_DEPTH;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 4;
   localparam logic [IRQ_W-1:0] ENABLE_KEEP = 8'h55;   // bit 2*c for each channel

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              irq;
      logic              access_error;
   } port_reply;

   // Predicts each response of the port and checks what comes back
   class mailbox_scoreboard;
      logic [DATA_W-1:0] words [CHANNELS][FIFO_DEPTH];
      int                head [CHANNELS];
      int                count [CHANNELS];
      logic [IRQ_W-1:0]  irq_enable;
      logic [IRQ_W-1:0]  irq_pending;
      port_reply         awaited [$];
      int                failures;

      function new();
         for (int c = 0; c < CHANNELS; c++) begin
            head[c]  = 0;
            count[c] = 0;
         end
         irq_enable  = '0;
         irq_pending = '0;
         failures    = 0;
      endfunction

      // Apply one accepted transaction to the shadow state and queue its reply
      function void note_request(cmd_type cmd, logic [ADDR_W-1:0] addr,
                                 logic [DATA_W-1:0] wdata);
         int         ch;
         int         tail;
         region_type region;
         port_reply  r;
         ch = addr[3:2];
         r  = '0;
         if (addr[1:0] != 2'b00) region = REG_NONE;
         else if (addr == ADDR_IRQ_EN) region = REG_IRQ_EN;
         else if (addr == ADDR_IRQ_STA) region = REG_IRQ_STA;
         else if (addr[6:4] == GRP_STATUS && ch < CHANNELS) region = REG_STATUS;
         else if (addr[6:4] == GRP_FIFO && ch < CHANNELS) region = REG_FIFO;
         else region = REG_NONE;

         case (region)
            REG_IRQ_EN: begin
               if (cmd == CMD_WRITE) irq_enable = wdata[IRQ_W-1:0] & ENABLE_KEEP;
               else r.read_data = DATA_W'(irq_enable);
            end
            REG_IRQ_STA: begin
               // write-one-to-clear
               if (cmd == CMD_WRITE) irq_pending = irq_pending & ~wdata[IRQ_W-1:0];
               else r.read_data = DATA_W'(irq_pending);
            end
            REG_STATUS: begin
               if (cmd == CMD_READ) r.read_data = DATA_W'(count[ch]) & COUNT_MASK;
            end
            REG_FIFO: begin
               if (cmd == CMD_WRITE) begin
                  // drop the word when full
                  if (count[ch] >= FIFO_DEPTH) begin
                     r.access_error = 1'b1;
                  end else begin
                     tail = (head[ch] + count[ch]) % FIFO_DEPTH;
                     words[ch][tail] = wdata;
                     count[ch]++;
                     irq_pending[2*ch] = 1'b1;
                  end
               end else begin
                  if (count[ch] == 0) begin
                     r.access_error = 1'b1;
                  end else begin
                     r.read_data = words[ch][head[ch]];
                     head[ch] = (head[ch] + 1) % FIFO_DEPTH;
                     count[ch]--;
                  end
               end
            end
            default: r.access_error = 1'b1;
         endcase
         r.irq = |(irq_pending & irq_enable);
         awaited.push_back(r);
      endfunction

      // Compare one response against the oldest queued reply
      function void check_response(logic [DATA_W-1:0] rd, logic irq, logic err);
         port_reply e;
         if (awaited.size() == 0) begin
            $error("response with no transaction outstanding: read_data %h", rd);
            failures++;
            return;
         end
         e = awaited.pop_front();
         if (rd !== e.read_data) begin
            $error("read_data: expected %h, actual %h", e.read_data, rd);
            failures++;
         end
         if (irq !== e.irq) begin
            $error("irq: expected %b, actual %b", e.irq, irq);
            failures++;
         end
         if (err !== e.access_error) begin
            $error("access_error: expected %b, actual %b", e.access_error, err);
            failures++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_command = 1'b0;
   logic [ADDR_W-1:0] req_address = '0;
   logic [DATA_W-1:0] req_write_data = '0;
   logic              rsp_valid;
   logic [DATA_W-1:0] rsp_read_data;
   logic              rsp_irq;
   logic              rsp_access_error;

   mailbox_scoreboard mailbox_sb;
   bit                gaps_on = 1'b0;
   int                cycle_count = 0;

   mailbox_fifo_channels #(
      .CHANNELS  (CHANNELS),
      .FIFO_DEPTH(FIFO_DEPTH)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_address     (req_address),
      .req_write_data  (req_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_read_data   (rsp_read_data),
      .rsp_irq         (rsp_irq),
      .rsp_access_error(rsp_access_error)
   );

   always #5 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("mailbox_fifo_channels regression: fail");
         $finish;
      end
   end

   // Watch both channels at each edge, using the values held before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) mailbox_sb.check_response(rsp_read_data, rsp_irq, rsp_access_error);
         if (start && !busy) begin
            mailbox_sb.note_request(cmd_type'(req_command), req_address, req_write_data);
         end
      end
   end

   function automatic logic [ADDR_W-1:0] fifo_addr(int ch);
      return {GRP_FIFO, 2'(ch), 2'b00};
   endfunction

   function automatic logic [ADDR_W-1:0] status_addr(int ch);
      return {GRP_STATUS, 2'(ch), 2'b00};
   endfunction

   // Issue one transaction, optionally after an idle gap; return at its accept edge
   task automatic issue(cmd_type cmd, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
      int gap;
      gap = gaps_on ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_command    <= cmd;
      req_address    <= addr;
      req_write_data <= data;
      do @(posedge clock); while (busy);
   endtask

   // Draw one transaction, half the time FIFO traffic with the given share of pushes
   task automatic random_access(int push_share);
      int                pick;
      cmd_type           cmd;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
      pick = $urandom_range(0, 99);
      cmd  = cmd_type'($urandom_range(0, 1));
      data = $urandom;
      if (pick < 50) begin
         addr = fifo_addr($urandom_range(0, CHANNELS - 1));
         cmd  = ($urandom_range(0, 99) < push_share) ? CMD_WRITE : CMD_READ;
      end else if (pick < 62) begin
         addr = status_addr($urandom_range(0, CHANNELS - 1));
      end else if (pick < 72) begin
         addr = ADDR_IRQ_EN;
      end else if (pick < 82) begin
         addr = ADDR_IRQ_STA;
         // clear only a few bits half of the time
         if ($urandom_range(0, 1)) data = data & $urandom & $urandom;
      end else begin
         addr = ADDR_W'($urandom_range(0, 127));
      end
      issue(cmd, addr, data);
   endtask

   initial begin
      mailbox_sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: register map, FIFO corners and error cases
      issue(CMD_READ, ADDR_IRQ_EN, 32'h0);
      issue(CMD_WRITE, ADDR_IRQ_EN, 32'hFFFF_FFFF);
      issue(CMD_READ, ADDR_IRQ_EN, 32'hFFFF_FFFF);
      issue(CMD_READ, fifo_addr(3), 32'h0);
      issue(CMD_WRITE, fifo_addr(0), 32'hFFFF_FFFF);
      issue(CMD_WRITE, fifo_addr(0), 32'h0);
      issue(CMD_READ, status_addr(0), 32'h0);
      issue(CMD_WRITE, status_addr(0), 32'hFFFF_FFFF);
      issue(CMD_READ, ADDR_IRQ_STA, 32'h0);
      issue(CMD_WRITE, ADDR_IRQ_STA, 32'hFFFF_FFFF);
      issue(CMD_READ, fifo_addr(0), 32'h0);
      issue(CMD_READ, fifo_addr(0), 32'h0);
      // fill channel 2 and push once more into the full FIFO
      repeat (FIFO_DEPTH + 1) issue(CMD_WRITE, fifo_addr(2), $urandom);
      issue(CMD_READ, status_addr(2), 32'h0);
      issue(CMD_READ, 7'h7F, 32'h0);
      issue(CMD_WRITE, 7'h00, 32'hA5A5_A5A5);
      issue(CMD_READ, 7'h22, 32'h0);
      issue(CMD_WRITE, 7'h40, 32'h5A5A_5A5A);

      // Random: blocks with their own push share and idle behavior
      for (int blk = 0; blk < 10; blk++) begin
         int push_share;
         push_share = $urandom_range(10, 90);
         gaps_on    = $urandom_range(0, 1);
         repeat (100) random_access(push_share);
      end

      // Drain outstanding responses
      start <= 1'b0;
      while (mailbox_sb.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mailbox_sb.failures == 0 && mailbox_sb.awaited.size() == 0) begin
         $display("mailbox_fifo_channels regression: pass");
      end else begin
         $display("mailbox_fifo_channels regression: fail");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/mfc_pkg.sv
src/mfc_ram.sv
src/mailbox_fifo_channels.sv
src/mfc_checker.sv
test/mailbox_fifo_channels_tb.sv
